// File: sv/stpn_pkg.sv
// Shared types and constants for the sorted-table prefix narrowing block.
// Used by the channel interfaces, the top level and the checker.
package stpn_pkg;

    localparam int ENTRIES      = 256;
    localparam int STRING_BYTES = 32;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int COUNT_W = IDX_W + 1;
    localparam int POS_W   = $clog2(STRING_BYTES);
    localparam int COL_W   = POS_W + 1;
    localparam int ADDR_W  = IDX_W + POS_W;
    localparam int DEPTH   = ENTRIES * STRING_BYTES;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CARET_CHAR = 8'h5E;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SRCH_LOWER,
        SRCH_UPPER,
        SRCH_CARET
    } search_t;

endpackage

// File: sv/stpn_in_if.sv
// Input channel of the prefix narrowing block: table writes and query characters.
// Depends on stpn_pkg for field widths.
interface stpn_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [stpn_pkg::IDX_W-1:0]        entry;
    logic [stpn_pkg::POS_W-1:0]        position;
    logic [stpn_pkg::BYTE_W-1:0]       byte_value;
    logic                              first;

    modport source (output valid, func, entry, position, byte_value, first, input ready);
    modport sink   (input valid, func, entry, position, byte_value, first, output ready);
endinterface

// File: sv/stpn_out_if.sv
// Result channel of the prefix narrowing block: one result per query character.
// Depends on stpn_pkg for field widths.
interface stpn_out_if;
    logic                              valid;
    logic                              ready;
    logic                              range_open;
    logic                              found;
    logic [stpn_pkg::IDX_W-1:0]        match_entry;
    logic [stpn_pkg::POS_W-1:0]        prefix_length;
    logic [stpn_pkg::COUNT_W-1:0]      range_low;
    logic [stpn_pkg::COUNT_W-1:0]      range_high;

    modport source (output valid, range_open, found, match_entry, prefix_length,
                    range_low, range_high, input ready);
    modport sink   (input valid, range_open, found, match_entry, prefix_length,
                    range_low, range_high, output ready);
endinterface

// File: sv/sorted_table_prefix_narrowing_top.sv
// Top level of the sorted-table prefix narrowing block: table memory, shared
// binary search unit and its sequencer. Depends on stpn_pkg, stpn_in_if, stpn_out_if.
//
// Usage:
// The in_ch channel carries two kinds of transfer. With func low it writes one
// byte of the string table (entry, position, byte_value) and gives no result.
// With func high it presents one query character; first starts a new query
// over entries [0, entry_count), with entry_count capped at 256. Each query
// character gives one transfer on out_ch with the narrowed range and any prefix
// entry found before narrowing. entry_count is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, as the block itself does
// not enforce this. A table write leaves the sequencer idle. A query character
// runs up to three binary searches (caret, lower bound, upper bound) on one
// shared compare unit reading the one-port table memory; each probe passes
// through the address state, where the read is registered, then the compare state.
// in_ch.ready is high only while the sequencer is idle.
// Reset clears the range, sets the column to one and entry_count to zero;
// the table contents stay undefined until written. If the receiver stalls,
// the result waits in the output register; the next item is still accepted,
// but its result is held back until the previous one has been taken.
module sorted_table_prefix_narrowing_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stpn_pkg::COUNT_W-1:0]    cfg_wdata,
    stpn_in_if.sink                         in_ch,
    stpn_out_if.source                      out_ch
);

    localparam int IW = stpn_pkg::IDX_W;
    localparam int CW = stpn_pkg::COUNT_W;
    localparam int PW = stpn_pkg::POS_W;
    localparam int LW = stpn_pkg::COL_W;
    localparam int AW = stpn_pkg::ADDR_W;
    localparam int BW = stpn_pkg::BYTE_W;

    logic [BW-1:0] mem [stpn_pkg::DEPTH];
    logic [BW-1:0] rdata_reg;

    stpn_pkg::state_t  state_reg, state_next;
    stpn_pkg::search_t mode_reg, mode_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] low_reg, low_next;
    logic [CW-1:0] high_reg, high_next;
    logic [LW-1:0] column_reg, column_next;
    logic [CW-1:0] s_lo_reg, s_lo_next;
    logic [CW-1:0] s_hi_reg, s_hi_next;
    logic [IW-1:0] mid_reg, mid_next;
    logic [BW-1:0] key_reg, key_next;
    logic          found_reg, found_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic [PW-1:0] plen_reg, plen_next;

    logic          out_valid_reg, out_valid_next;
    logic          o_open_reg, o_open_next;
    logic          o_found_reg, o_found_next;
    logic [IW-1:0] o_entry_reg, o_entry_next;
    logic [PW-1:0] o_plen_reg, o_plen_next;
    logic [CW-1:0] o_low_reg, o_low_next;
    logic [CW-1:0] o_high_reg, o_high_next;

    logic          in_xfer;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [CW-1:0] mid;
    logic [CW-1:0] first_high;

    assign in_ch.ready = (state_reg == stpn_pkg::ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    assign mid = s_lo_reg + ((s_hi_reg - s_lo_reg) >> 1);

    assign first_high = (count_reg > CW'(stpn_pkg::ENTRIES)) ?
                        CW'(stpn_pkg::ENTRIES) : count_reg;

    // Single port: writes happen only in idle, probes only in the address state.
    assign mem_we   = in_xfer && (in_ch.func == stpn_pkg::FUNC_WRITE);
    assign mem_re   = (state_reg == stpn_pkg::ST_ADDR) && (s_lo_reg < s_hi_reg);
    assign mem_addr = mem_we ? {in_ch.entry, in_ch.position}
                             : {mid[IW-1:0], column_reg[PW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= in_ch.byte_value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stpn_pkg::ST_IDLE;
            mode_reg      <= stpn_pkg::SRCH_LOWER;
            low_reg       <= '0;
            high_reg      <= '0;
            column_reg    <= LW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            column_reg    <= column_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_lo_reg    <= s_lo_next;
        s_hi_reg    <= s_hi_next;
        mid_reg     <= mid_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        hit_reg     <= hit_next;
        plen_reg    <= plen_next;
        o_open_reg  <= o_open_next;
        o_found_reg <= o_found_next;
        o_entry_reg <= o_entry_next;
        o_plen_reg  <= o_plen_next;
        o_low_reg   <= o_low_next;
        o_high_reg  <= o_high_next;
    end

    always_comb
    begin
        logic go_right;
        logic go_left;

        go_right       = 1'b0;
        go_left        = 1'b0;
        state_next     = state_reg;
        mode_next      = mode_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        column_next    = column_reg;
        s_lo_next      = s_lo_reg;
        s_hi_next      = s_hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        plen_next      = plen_reg;
        out_valid_next = out_valid_reg;
        o_open_next    = o_open_reg;
        o_found_next   = o_found_reg;
        o_entry_next   = o_entry_reg;
        o_plen_next    = o_plen_reg;
        o_low_next     = o_low_reg;
        o_high_next    = o_high_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            stpn_pkg::ST_IDLE:
            begin
                if (in_xfer && (in_ch.func == stpn_pkg::FUNC_QUERY))
                begin
                    key_next   = in_ch.byte_value;
                    found_next = 1'b0;
                    hit_next   = '0;
                    plen_next  = '0;
                    if (in_ch.first)
                    begin
                        low_next    = '0;
                        high_next   = first_high;
                        column_next = LW'(1);
                        mode_next   = stpn_pkg::SRCH_LOWER;
                        s_lo_next   = '0;
                        s_hi_next   = first_high;
                        state_next  = stpn_pkg::ST_ADDR;
                    end
                    else if (low_reg < high_reg)
                    begin
                        if (column_reg >= LW'(stpn_pkg::STRING_BYTES))
                        begin
                            // String limit reached: the range closes.
                            high_next  = low_reg;
                            state_next = stpn_pkg::ST_DONE;
                        end
                        else
                        begin
                            mode_next  = stpn_pkg::SRCH_CARET;
                            s_lo_next  = low_reg;
                            s_hi_next  = high_reg;
                            state_next = stpn_pkg::ST_ADDR;
                        end
                    end
                    else
                    begin
                        state_next = stpn_pkg::ST_DONE;
                    end
                end
            end

            stpn_pkg::ST_ADDR:
            begin
                if (s_lo_reg < s_hi_reg)
                begin
                    mid_next   = mid[IW-1:0];
                    state_next = stpn_pkg::ST_CMP;
                end
                else
                begin
                    case (mode_reg)
                        stpn_pkg::SRCH_LOWER:
                        begin
                            low_next  = s_lo_reg;
                            mode_next = stpn_pkg::SRCH_UPPER;
                            s_hi_next = high_reg;
                        end
                        stpn_pkg::SRCH_UPPER:
                        begin
                            high_next = s_lo_reg;
                            if (column_reg < LW'(stpn_pkg::STRING_BYTES))
                            begin
                                column_next = column_reg + LW'(1);
                            end
                            state_next = stpn_pkg::ST_DONE;
                        end
                        default:
                        begin
                            // Caret search missed; narrow the whole range.
                            mode_next = stpn_pkg::SRCH_LOWER;
                            s_lo_next = low_reg;
                            s_hi_next = high_reg;
                        end
                    endcase
                end
            end

            stpn_pkg::ST_CMP:
            begin
                state_next = stpn_pkg::ST_ADDR;
                case (mode_reg)
                    stpn_pkg::SRCH_LOWER:
                    begin
                        go_right = (rdata_reg < key_reg);
                        go_left  = !go_right;
                    end
                    stpn_pkg::SRCH_UPPER:
                    begin
                        go_right = (rdata_reg <= key_reg);
                        go_left  = !go_right;
                    end
                    default:
                    begin
                        go_right = (rdata_reg < stpn_pkg::CARET_CHAR);
                        go_left  = (rdata_reg > stpn_pkg::CARET_CHAR);
                    end
                endcase
                if (go_right)
                begin
                    s_lo_next = {1'b0, mid_reg} + CW'(1);
                end
                else if (go_left)
                begin
                    s_hi_next = {1'b0, mid_reg};
                end
                else
                begin
                    found_next = 1'b1;
                    hit_next   = mid_reg;
                    plen_next  = PW'(column_reg - LW'(1));
                    mode_next  = stpn_pkg::SRCH_LOWER;
                    s_lo_next  = low_reg;
                    s_hi_next  = high_reg;
                end
            end

            stpn_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    o_open_next    = (low_reg < high_reg);
                    o_found_next   = found_reg;
                    o_entry_next   = hit_reg;
                    o_plen_next    = plen_reg;
                    o_low_next     = low_reg;
                    o_high_next    = high_reg;
                    state_next     = stpn_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stpn_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.range_open    = o_open_reg;
    assign out_ch.found         = o_found_reg;
    assign out_ch.match_entry   = o_entry_reg;
    assign out_ch.prefix_length = o_plen_reg;
    assign out_ch.range_low     = o_low_reg;
    assign out_ch.range_high    = o_high_reg;

endmodule

// File: sv/stpn_checker.sv
// Port-level checker for the prefix narrowing block, bound to the top level.
// Depends on stpn_pkg for field widths.
module stpn_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            in_func,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            out_range_open,
    input  logic                            out_found,
    input  logic [stpn_pkg::IDX_W-1:0]      out_match_entry,
    input  logic [stpn_pkg::POS_W-1:0]      out_prefix_length,
    input  logic [stpn_pkg::COUNT_W-1:0]    out_range_low,
    input  logic [stpn_pkg::COUNT_W-1:0]    out_range_high
);

    // A pending result is not withdrawn before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // The open flag agrees with the reported bounds, the bounds are ordered, and the upper bound is at most ENTRIES.
    a_range_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_range_open == (out_range_low < out_range_high)) &&
                      (out_range_low <= out_range_high) &&
                      (out_range_high <= stpn_pkg::COUNT_W'(stpn_pkg::ENTRIES)))
        else $error("inconsistent range in result");

    // Without a prefix hit the hit fields read as zero.
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> (out_match_entry == '0) && (out_prefix_length == '0))
        else $error("hit fields set without a hit");

    // After a query transfer the input is not ready in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_func == stpn_pkg::FUNC_QUERY) |=> !in_ready)
        else $error("input ready right after a query transfer");

endmodule

bind sorted_table_prefix_narrowing_top stpn_checker u_stpn_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_func           (in_ch.func),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_range_open    (out_ch.range_open),
    .out_found         (out_ch.found),
    .out_match_entry   (out_ch.match_entry),
    .out_prefix_length (out_ch.prefix_length),
    .out_range_low     (out_ch.range_low),
    .out_range_high    (out_ch.range_high)
);
